// ----- src/bdbb_pkg.sv -----
// Shared types and constants for the dual-bound Bellman backup unit.
// Used by bdbb_ctrl, bdbb_datapath and the top level; depends on nothing.
package bdbb_pkg;

  localparam int MAX_ACTIONS_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int PROB_W     = 16;   // Q0.16 probability and discount
  localparam int IN_VAL_W   = 32;   // Q16.16 field width on the ports
  localparam int ACT_IDX_W  = 6;    // action index field width
  localparam int ACC_W      = 56;   // Q24.32 accumulator
  localparam int PROD_W     = PROB_W + IN_VAL_W;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 144;

  localparam logic [PROB_W-1:0] DISCOUNT_RESET = 16'd62259;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic acc;
    logic scale;
    logic qform;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic last_o;
    logic out_free;
  } sts_t;

endpackage

// ----- src/bdbb_ctrl.sv -----
// Sequencer for the dual-bound backup: steps one request through the datapath.
// Depends on bdbb_pkg for the command and status types.
module bdbb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bdbb_pkg::sts_t sts,
  output bdbb_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_SCL   = 6'b001000,
    ST_QFORM = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_o ? ST_SCL : ST_IDLE;
      end
      ST_SCL: begin
        cmd.scale = 1'b1;
        state_nxt = ST_QFORM;
      end
      ST_QFORM: begin
        cmd.qform = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/bdbb_datapath.sv -----
// Datapath for the dual-bound backup: multipliers, accumulators, Q forming,
// running best and the output register. Depends on bdbb_pkg.
module bdbb_datapath #(
  parameter int MAX_ACTIONS = bdbb_pkg::MAX_ACTIONS_DEF,
  parameter int VALUE_WIDTH = bdbb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdbb_pkg::cmd_t                      cmd,
  output bdbb_pkg::sts_t                      sts,
  input  logic [bdbb_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tuser,
  input  logic                                cfg_wr_en,
  input  logic [bdbb_pkg::PROB_W-1:0]         cfg_wr_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bdbb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int PW     = bdbb_pkg::PROB_W;
  localparam int IW     = bdbb_pkg::IN_VAL_W;
  localparam int AW     = bdbb_pkg::ACC_W;
  localparam int PRW    = bdbb_pkg::PROD_W;
  localparam int XW     = bdbb_pkg::ACT_IDX_W;
  localparam int VW     = VALUE_WIDTH;
  localparam int ACT_W  = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int S16_W  = AW - 16;
  localparam int SC_W   = S16_W + PW + 1;
  localparam int TERM_W = SC_W - 16;
  localparam int QS_W   = ((VW > TERM_W) ? VW : TERM_W) + 1;
  localparam int CMP_W  = (VW > IW) ? VW : IW;

  localparam logic signed [AW-1:0]   ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0]   ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [VW-1:0]   VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [QS_W-1:0] VMAX_X  = {{(QS_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [QS_W-1:0] VMIN_X  = {{(QS_W-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic [ACT_W-1:0]       ACT_LAST = ACT_W'(MAX_ACTIONS - 1);

  // configuration
  logic [PW-1:0] discount_r;

  // latched request
  logic [PW-1:0]        prob_r;
  logic signed [IW-1:0] nl_r, nu_r, rw_r, pl_r, pu_r;
  logic                 lo_r, la_r;

  // arithmetic stages
  logic signed [PRW-1:0]    prod_l_r, prod_u_r;
  logic signed [PRW:0]      mul_l, mul_u;
  logic signed [AW-1:0]     acc_l_r, acc_u_r, acc_l_nxt, acc_u_nxt;
  logic signed [AW:0]       sum_l, sum_u;
  logic signed [SC_W-1:0]   sc_l, sc_u;
  logic signed [TERM_W-1:0] term_l_r, term_u_r;
  logic signed [QS_W-1:0]   qs_l, qs_u;
  logic signed [VW-1:0]     ql_r, qu_r;

  // node state
  logic [ACT_W-1:0]     act_r;
  logic signed [VW-1:0] best_l_r, best_u_r, best_l_nxt, best_u_nxt;
  logic [ACT_W-1:0]     best_act_r, best_act_nxt;
  logic signed [CMP_W-1:0] node_l, node_u;

  // output register
  logic                 out_tvalid_r;
  logic [XW-1:0]        o_act_r, o_best_r;
  logic [IW-1:0]        o_ql_r, o_qu_r, o_nl_r, o_nu_r;
  logic                 o_last_r;

  assign sts.last_o   = lo_r;
  assign sts.out_free = !out_tvalid_r || out_tready;

  assign mul_l = $signed({1'b0, prob_r}) * nl_r;
  assign mul_u = $signed({1'b0, prob_r}) * nu_r;

  assign sum_l = (AW+1)'(acc_l_r) + (AW+1)'(prod_l_r);
  assign sum_u = (AW+1)'(acc_u_r) + (AW+1)'(prod_u_r);

  always_comb begin
    if (sum_l[AW] != sum_l[AW-1]) begin
      acc_l_nxt = sum_l[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_l_nxt = sum_l[AW-1:0];
    end
    if (sum_u[AW] != sum_u[AW-1]) begin
      acc_u_nxt = sum_u[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_u_nxt = sum_u[AW-1:0];
    end
  end

  assign sc_l = $signed(acc_l_r[AW-1:16]) * $signed({1'b0, discount_r});
  assign sc_u = $signed(acc_u_r[AW-1:16]) * $signed({1'b0, discount_r});

  assign qs_l = QS_W'(rw_r) + QS_W'(term_l_r);
  assign qs_u = QS_W'(rw_r) + QS_W'(term_u_r);

  // running best; strict compare keeps the first action on a tie
  always_comb begin
    best_l_nxt   = (ql_r > best_l_r) ? ql_r : best_l_r;
    best_u_nxt   = best_u_r;
    best_act_nxt = best_act_r;
    if (qu_r > best_u_r) begin
      best_u_nxt   = qu_r;
      best_act_nxt = act_r;
    end
    node_l = (CMP_W'(pl_r) > CMP_W'(best_l_nxt)) ? CMP_W'(pl_r) : CMP_W'(best_l_nxt);
    node_u = (CMP_W'(pu_r) < CMP_W'(best_u_nxt)) ? CMP_W'(pu_r) : CMP_W'(best_u_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r <= bdbb_pkg::DISCOUNT_RESET;
    end else if (cfg_wr_en) begin
      discount_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      prob_r <= in_tdata[15:0];
      nl_r   <= in_tdata[47:16];
      nu_r   <= in_tdata[79:48];
      rw_r   <= in_tdata[111:80];
      pl_r   <= in_tdata[143:112];
      pu_r   <= in_tdata[175:144];
      la_r   <= in_tuser;
    end
    if (cmd.mul) begin
      prod_l_r <= mul_l[PRW-1:0];
      prod_u_r <= mul_u[PRW-1:0];
    end
    if (cmd.scale) begin
      term_l_r <= sc_l[SC_W-1:16];
      term_u_r <= sc_u[SC_W-1:16];
    end
    if (cmd.qform) begin
      if (qs_l > VMAX_X) begin
        ql_r <= VMAX_X[VW-1:0];
      end else if (qs_l < VMIN_X) begin
        ql_r <= VMIN_X[VW-1:0];
      end else begin
        ql_r <= qs_l[VW-1:0];
      end
      if (qs_u > VMAX_X) begin
        qu_r <= VMAX_X[VW-1:0];
      end else if (qs_u < VMIN_X) begin
        qu_r <= VMIN_X[VW-1:0];
      end else begin
        qu_r <= qs_u[VW-1:0];
      end
    end
    if (cmd.update) begin
      o_act_r  <= XW'(act_r);
      o_ql_r   <= IW'(CMP_W'(ql_r));
      o_qu_r   <= IW'(CMP_W'(qu_r));
      o_last_r <= la_r;
      if (la_r) begin
        o_nl_r   <= node_l[IW-1:0];
        o_nu_r   <= node_u[IW-1:0];
        o_best_r <= XW'(best_act_nxt);
      end else begin
        o_nl_r   <= '0;
        o_nu_r   <= '0;
        o_best_r <= '0;
      end
    end
  end

  // last-outcome flag is control: it steers the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= 1'b0;
    end else if (cmd.load_in) begin
      lo_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_l_r    <= '0;
      acc_u_r    <= '0;
      act_r      <= '0;
      best_l_r   <= VAL_MIN;
      best_u_r   <= VAL_MIN;
      best_act_r <= '0;
    end else if (cmd.acc) begin
      acc_l_r <= acc_l_nxt;
      acc_u_r <= acc_u_nxt;
    end else if (cmd.update) begin
      acc_l_r <= '0;
      acc_u_r <= '0;
      if (la_r) begin
        act_r      <= '0;
        best_l_r   <= VAL_MIN;
        best_u_r   <= VAL_MIN;
        best_act_r <= '0;
      end else begin
        best_l_r   <= best_l_nxt;
        best_u_r   <= best_u_nxt;
        best_act_r <= best_act_nxt;
        if (act_r != ACT_LAST) begin
          act_r <= act_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.update) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0, o_best_r, o_nu_r, o_nl_r, o_qu_r, o_ql_r, o_act_r};

endmodule

// ----- src/bellman_dual_bound_backup_unit.sv -----
// Top level of the dual-bound Bellman backup unit.
// Instantiates bdbb_ctrl and bdbb_datapath; depends on bdbb_pkg.
//
// Takes one outcome per request and folds probability times the successor's
// lower and upper bounds into two saturating Q24.32 accumulators. An outcome
// that closes an action (in_tlast) yields one result with the action's lower
// and upper Q (reward + discount * sum, saturated Q16.16); a closing outcome
// that also ends the node (in_tuser) carries the new node bounds and the best
// action, with out_tlast set. A plain outcome steps through accept, multiply
// and accumulate; a closing outcome adds the discount multiply, Q forming and
// best update, and stays in the update step while the output register is
// still held by an untaken result. The single shared sequencer steps every
// request: one request is in flight at a time. The output register lets a
// new request enter while the previous result waits.
module bellman_dual_bound_backup_unit #(
  parameter int MAX_ACTIONS = bdbb_pkg::MAX_ACTIONS_DEF,
  parameter int VALUE_WIDTH = bdbb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // obs_prob, next_lower, next_upper, reward, prior_lower, prior_upper
  input  logic [bdbb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tlast,   // last_outcome
  input  logic                             in_tuser,   // last_action
  input  logic                             cfg_wr_en,
  input  logic [bdbb_pkg::PROB_W-1:0]      cfg_wr_data, // discount
  // action_index, q_lower, q_upper, node_lower, node_upper, best_action, pad
  output logic [bdbb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic                             out_tlast   // is_final
);

  bdbb_pkg::cmd_t cmd;
  bdbb_pkg::sts_t sts;

  bdbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdbb_datapath #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.mul || cmd.acc || cmd.scale || cmd.qform || cmd.update))
    else $error("datapath busy while accepting");

  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.mul)
    else $error("accepted request not multiplied");

  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> sts.out_free)
    else $error("result loaded over a waiting result");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.mul, cmd.acc, cmd.scale, cmd.qform, cmd.update}))
    else $error("more than one datapath command");

endmodule

// ----- verif/tb_bellman_dual_bound_backup_unit.sv -----
// Self-checking testbench for bellman_dual_bound_backup_unit: streams node outcomes,
// predicts every action backup and node bound update, and compares each result.
// Depends on bdbb_pkg and the unit's top level only.
`timescale 1ns / 1ps

module tb_bellman_dual_bound_backup_unit;

  localparam longint ACC_MAX      = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN      = -ACC_MAX - 1;
  localparam longint VAL_MAX      = 64'sd2147483647;
  localparam longint VAL_MIN      = -64'sd2147483648;
  localparam int     ACT_CAP      = bdbb_pkg::MAX_ACTIONS_DEF - 1;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     Q_MAX        = 32'h7FFF_FFFF;
  localparam int     Q_MIN        = 32'h8000_0000;

  typedef struct {
    bit [15:0] prob;
    int        nl;
    int        nu;
    int        rw;
    bit        lo;
    bit        la;
    int        pl;
    int        pu;
  } outcome_t;

  typedef struct {
    bit [5:0] act;
    int       ql;
    int       qu;
    bit       fin;
    int       node_lo;
    int       node_up;
    bit [5:0] best;
  } backup_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [bdbb_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic                             in_tlast = 1'b0;
  logic                             in_tuser = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [bdbb_pkg::PROB_W-1:0]      cfg_wr_data = '0;
  logic [bdbb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             out_tlast;

  // predictor state
  bit [15:0] discount_reg;
  longint    lower_acc;
  longint    upper_acc;
  int        act_cnt;
  longint    best_lo;
  longint    best_up;
  int        best_act;

  backup_t   backup_q[$];
  backup_t   mon_exp;
  int        err_cnt;
  int        cyc;
  int        send_idle_pct;
  int        recv_stall_pct;

  bellman_dual_bound_backup_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint q_value(longint acc, int rw);
    longint s16;
    longint d;
    longint term;
    s16  = acc >>> 16;
    d    = discount_reg;
    term = (s16 * d) >>> 16;
    return clamp(longint'(rw) + term, VAL_MIN, VAL_MAX);
  endfunction

  function automatic void clear_node();
    lower_acc = 0;
    upper_acc = 0;
    act_cnt   = 0;
    best_lo   = VAL_MIN;
    best_up   = VAL_MIN;
    best_act  = 0;
  endfunction

  function automatic void bellman_predict(outcome_t o);
    backup_t r;
    longint  ql;
    longint  qu;
    lower_acc = clamp(lower_acc + longint'(o.prob) * longint'(o.nl), ACC_MIN, ACC_MAX);
    upper_acc = clamp(upper_acc + longint'(o.prob) * longint'(o.nu), ACC_MIN, ACC_MAX);
    if (!o.lo) return;
    ql = q_value(lower_acc, o.rw);
    qu = q_value(upper_acc, o.rw);
    if (ql > best_lo) best_lo = ql;
    if (qu > best_up) begin
      best_up  = qu;
      best_act = act_cnt;
    end
    r.act = act_cnt[5:0];
    r.ql  = int'(ql);
    r.qu  = int'(qu);
    if (o.la) begin
      r.fin     = 1'b1;
      r.node_lo = int'((longint'(o.pl) > best_lo) ? longint'(o.pl) : best_lo);
      r.node_up = int'((longint'(o.pu) < best_up) ? longint'(o.pu) : best_up);
      r.best    = best_act[5:0];
      clear_node();
    end else begin
      r.fin     = 1'b0;
      r.node_lo = 0;
      r.node_up = 0;
      r.best    = '0;
      lower_acc = 0;
      upper_acc = 0;
      if (act_cnt < ACT_CAP) act_cnt++;
    end
    backup_q.push_back(r);
  endfunction

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // result side: random stall, compare against oldest expected backup
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (backup_q.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        mon_exp = backup_q.pop_front();
        check_field("action_index", mon_exp.act, out_tdata[5:0]);
        check_field("q_lower", mon_exp.ql, longint'($signed(out_tdata[37:6])));
        check_field("q_upper", mon_exp.qu, longint'($signed(out_tdata[69:38])));
        check_field("is_final", mon_exp.fin, out_tlast);
        check_field("node_lower", mon_exp.node_lo, longint'($signed(out_tdata[101:70])));
        check_field("node_upper", mon_exp.node_up, longint'($signed(out_tdata[133:102])));
        check_field("best_action", mon_exp.best, out_tdata[139:134]);
      end
    end
  end

  function automatic outcome_t mk(bit [15:0] prob, int nl, int nu, int rw, bit lo, bit la,
                                  int pl, int pu);
    outcome_t o;
    o.prob = prob; o.nl = nl; o.nu = nu; o.rw = rw;
    o.lo = lo; o.la = la; o.pl = pl; o.pu = pu;
    return o;
  endfunction

  function automatic int rand_val();
    case ($urandom_range(0, 5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return int'($urandom);
      default: return int'($urandom_range(0, 1310720)) - 655360;
    endcase
  endfunction

  function automatic bit [15:0] rand_prob();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_outcome(input outcome_t o);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {o.pu, o.pl, o.rw, o.nu, o.nl, o.prob};
    in_tlast  <= o.lo;
    in_tuser  <= o.la;
    do @(posedge clk); while (!in_tready);
    bellman_predict(o);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (backup_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_discount(input bit [15:0] v);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    discount_reg = v;
  endtask

  // full-scale inputs; the first two outcomes drive both Q values into saturation
  task automatic test_extremes();
    send_outcome(mk(16'hFFFF, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b0, 0, 0));
    send_outcome(mk(16'hFFFF, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b0, 0, 0));
    send_outcome(mk(16'hFFFF, Q_MIN, Q_MAX, 0, 1'b1, 1'b1, Q_MAX, Q_MIN));
    send_outcome(mk(16'd1, -1, 1, -1, 1'b1, 1'b1, Q_MIN, Q_MAX));
  endtask

  task automatic test_absent_outcome();
    send_outcome(mk(16'd0, Q_MAX, Q_MIN, 32'h0001_8000, 1'b0, 1'b0, 0, 0));
    send_outcome(mk(16'd0, Q_MIN, Q_MAX, 32'h0002_0000, 1'b1, 1'b1, 0, 32'h0010_0000));
  endtask

  task automatic test_tie_first_wins();
    send_outcome(mk(16'h8000, 32'h0001_0000, 32'h0004_0000, 32'h0000_4000, 1'b1, 1'b0, 0, 0));
    send_outcome(mk(16'h8000, 32'h0001_0000, 32'h0004_0000, 32'h0000_4000, 1'b1, 1'b0, 0, 0));
    send_outcome(mk(16'h8000, 32'h0001_0000, 32'h0004_0000, 32'h0000_4000, 1'b1, 1'b1,
                    Q_MIN, Q_MAX));
  endtask

  // tuser without tlast must not close anything
  task automatic test_ignored_last_action();
    send_outcome(mk(16'h4000, 32'h0002_0000, 32'h0003_0000, Q_MAX, 1'b0, 1'b1, Q_MAX, Q_MIN));
    send_outcome(mk(16'h4000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1'b1, 1'b0, 0, 0));
    send_outcome(mk(16'h2000, -32'sd65536, 32'h0001_0000, 0, 1'b0, 1'b1, 0, 0));
    send_outcome(mk(16'h2000, -32'sd65536, 32'h0001_0000, 0, 1'b1, 1'b1, 0, Q_MAX));
  endtask

  task automatic test_all_most_negative();
    for (int a = 0; a < 3; a++)
      send_outcome(mk(16'hFFFF, Q_MIN, Q_MIN, Q_MIN, 1'b1, a == 2, Q_MIN, Q_MAX));
  endtask

  task automatic test_action_overflow();
    for (int a = 0; a < 70; a++)
      send_outcome(mk(rand_prob(), rand_val(), rand_val(), rand_val(), 1'b1, a == 69,
                      rand_val(), rand_val()));
  endtask

  task automatic test_acc_saturation();
    for (int i = 0; i < 262; i++)
      send_outcome(mk(16'hFFFF, Q_MAX, Q_MIN, 0, i == 261, 1'b0, 0, 0));
    for (int i = 0; i < 262; i++)
      send_outcome(mk(16'hFFFF, Q_MIN, Q_MAX, 0, i == 261, i == 261, rand_val(), rand_val()));
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                  input bit [15:0] disc);
    int sent;
    int n_act;
    int n_out;
    int rw;
    write_discount(disc);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      n_act = ($urandom_range(0, 99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int a = 0; a < n_act; a++) begin
        n_out = $urandom_range(1, 4);
        rw    = rand_val();
        for (int k = 0; k < n_out; k++) begin
          send_outcome(mk(rand_prob(), rand_val(), rand_val(),
                          (k == n_out - 1) ? rw : rand_val(),
                          k == n_out - 1,
                          (k == n_out - 1) ? (a == n_act - 1) : ($urandom_range(0, 3) == 0),
                          rand_val(), rand_val()));
          sent++;
        end
      end
    end
  endtask

  initial begin
    err_cnt        = 0;
    cyc            = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    discount_reg   = bdbb_pkg::DISCOUNT_RESET;
    clear_node();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_absent_outcome();
    test_tie_first_wins();
    test_ignored_last_action();
    test_all_most_negative();

    run_random_phase(160, 0, 0, 16'hFFFF);
    test_action_overflow();
    run_random_phase(160, 78, 0, 16'h0000);
    run_random_phase(160, 0, 78, 16'($urandom));
    run_random_phase(160, 35, 35, 16'h8000);
    test_acc_saturation();
    run_random_phase(160, 0, 0, bdbb_pkg::DISCOUNT_RESET);

    wait_drain();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
